>>> sv/alfr_pkg.sv
// Shared types and constants of the ASCII length frame receiver.
// Used by alfr_core and ascii_length_frame_receiver_top; depends on nothing else.
package alfr_pkg;

    // Kinds of input beat.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Kinds of result beat.
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // Error codes.
    localparam logic [1:0] ERR_COUNT_NOT_DIGIT = 2'd0;
    localparam logic [1:0] ERR_BAD_LENGTH      = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG        = 2'd2;
    localparam logic [1:0] ERR_TIMEOUT         = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_START_MARKER  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
    localparam logic [1:0] REG_MAX_FRAME     = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [31:0] START_MARKER_RESET  = 32'd0;
    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd300;
    localparam logic [15:0] MAX_FRAME_RESET     = 16'd4500;

    // Character and length constants.
    localparam logic [7:0]  CHAR_ZERO   = 8'h30;
    localparam logic [7:0]  CHAR_NINE   = 8'h39;
    localparam logic [2:0]  ID_BYTES    = 3'd4;
    localparam logic [16:0] ACCUM_MAX   = 17'h1FFFF;
    localparam logic [15:0] IDLE_MAX    = 16'hFFFF;
    localparam logic [1:0]  WINDOW_FULL = 2'd3;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_COUNT  = 2'd1,
        PH_DIGITS = 2'd2,
        PH_BODY   = 2'd3
    } phase_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] start_marker;
        logic [15:0] timeout_ticks;
        logic [15:0] max_frame;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] frame_byte;
        logic       is_id;
        logic       last;
        logic [1:0] error_code;
    } result_t;

endpackage

>>> sv/alfr_core.sv
// Frame parser state machine and datapath: one item per step, at most one result.
// Depends on alfr_pkg for the phase type, item, configuration and result structs.
module alfr_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  alfr_pkg::item_t  item,
    input  alfr_pkg::cfg_t   cfg,
    output alfr_pkg::result_t res
);
    import alfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [23:0] window_reg, window_next;
    logic [1:0]  fill_reg, fill_next;
    logic [3:0]  expected_reg, expected_next;
    logic [3:0]  seen_reg, seen_next;
    logic [16:0] accum_reg, accum_next;
    logic        bad_reg, bad_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] idle_reg, idle_next;

    logic        go_hunt, go_count, go_digits, go_body;
    logic        is_digit;
    logic [3:0]  digit_val;
    logic [31:0] cand;
    logic [15:0] idle_inc;
    logic [20:0] prod;
    logic [16:0] accum_upd;
    logic [3:0]  seen_inc;
    logic        bad_upd;
    logic [17:0] frame_len;

    assign is_digit  = (item.rx_byte >= CHAR_ZERO) && (item.rx_byte <= CHAR_NINE);
    assign digit_val = 4'(item.rx_byte - CHAR_ZERO);
    assign cand      = {window_reg, item.rx_byte};
    assign idle_inc  = (idle_reg < IDLE_MAX) ? idle_reg + 16'd1 : idle_reg;
    assign prod      = 21'(accum_reg) * 21'd10 + 21'(digit_val);
    assign accum_upd = is_digit ? ((prod > 21'(ACCUM_MAX)) ? ACCUM_MAX : prod[16:0])
                                : accum_reg;
    assign bad_upd   = bad_reg || !is_digit
                     || (is_digit && seen_reg == 4'd0 && item.rx_byte == CHAR_ZERO
                         && expected_reg > 4'd1);
    assign seen_inc  = seen_reg + 4'd1;
    assign frame_len = 18'(accum_upd) + 18'(ID_BYTES);

    // Datapath and result decode.
    always_comb
    begin
        window_next   = window_reg;
        fill_next     = fill_reg;
        expected_next = expected_reg;
        seen_next     = seen_reg;
        accum_next    = accum_reg;
        bad_next      = bad_reg;
        left_next     = left_reg;
        idle_next     = idle_reg;
        go_hunt       = 1'b0;
        go_count      = 1'b0;
        go_digits     = 1'b0;
        go_body       = 1'b0;
        res           = '0;

        if (item.op == OP_TICK)
        begin
            if (idle_inc >= cfg.timeout_ticks)
            begin
                idle_next = '0;
                if (phase_reg != PH_HUNT)
                begin
                    res.valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_TIMEOUT;
                    go_hunt        = 1'b1;
                end
                else
                begin
                    window_next = '0;
                    fill_next   = '0;
                end
            end
            else
            begin
                idle_next = idle_inc;
            end
        end
        else
        begin
            idle_next = '0;
            case (phase_reg)
                PH_HUNT:
                begin
                    if (fill_reg == WINDOW_FULL && cand == cfg.start_marker)
                    begin
                        window_next = '0;
                        fill_next   = '0;
                        go_count    = 1'b1;
                    end
                    else
                    begin
                        window_next = cand[23:0];
                        if (fill_reg != WINDOW_FULL)
                        begin
                            fill_next = fill_reg + 2'd1;
                        end
                    end
                end
                PH_COUNT:
                begin
                    if (!is_digit)
                    begin
                        res.valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_COUNT_NOT_DIGIT;
                        go_hunt        = 1'b1;
                    end
                    else if (item.rx_byte == CHAR_ZERO)
                    begin
                        res.valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_BAD_LENGTH;
                        go_hunt        = 1'b1;
                    end
                    else
                    begin
                        expected_next = digit_val;
                        seen_next     = '0;
                        accum_next    = '0;
                        bad_next      = 1'b0;
                        go_digits     = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    accum_next = accum_upd;
                    bad_next   = bad_upd;
                    seen_next  = seen_inc;
                    if (seen_inc >= expected_reg)
                    begin
                        if (bad_upd)
                        begin
                            res.valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_BAD_LENGTH;
                            go_hunt        = 1'b1;
                        end
                        else if (frame_len > 18'(cfg.max_frame))
                        begin
                            res.valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_TOO_LONG;
                            go_hunt        = 1'b1;
                        end
                        else
                        begin
                            left_next = frame_len[15:0];
                            go_body   = 1'b1;
                        end
                    end
                end
                PH_BODY:
                begin
                    res.valid      = 1'b1;
                    res.kind       = KIND_DATA;
                    res.frame_byte = item.rx_byte;
                    res.is_id      = (17'(left_reg) > accum_reg);
                    res.last       = (left_reg <= 16'd1);
                    if (left_reg <= 16'd1)
                    begin
                        go_hunt = 1'b1;
                    end
                    else
                    begin
                        left_next = left_reg - 16'd1;
                    end
                end
                default:
                begin
                    go_hunt = 1'b1;
                end
            endcase
        end

        // Leaving a frame for any reason starts the hunt from a clean slate.
        if (go_hunt)
        begin
            window_next   = '0;
            fill_next     = '0;
            expected_next = '0;
            seen_next     = '0;
            accum_next    = '0;
            bad_next      = 1'b0;
            left_next     = '0;
        end
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (go_hunt)
        begin
            phase_next = PH_HUNT;
        end
        else if (go_count)
        begin
            phase_next = PH_COUNT;
        end
        else if (go_digits)
        begin
            phase_next = PH_DIGITS;
        end
        else if (go_body)
        begin
            phase_next = PH_BODY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            window_reg   <= '0;
            fill_reg     <= '0;
            expected_reg <= '0;
            seen_reg     <= '0;
            accum_reg    <= '0;
            bad_reg      <= 1'b0;
            left_reg     <= '0;
            idle_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            window_reg   <= window_next;
            fill_reg     <= fill_next;
            expected_reg <= expected_next;
            seen_reg     <= seen_next;
            accum_reg    <= accum_next;
            bad_reg      <= bad_next;
            left_reg     <= left_next;
            idle_reg     <= idle_next;
        end
    end

    // An error always sends the parser back to hunting with an empty window.
    a_error_hunts: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid && res.kind == KIND_ERROR
        |=> phase_reg == PH_HUNT && fill_reg == 2'd0)
        else $error("error result did not return the parser to hunting");

    // While forwarding there is always at least one byte left to send.
    a_body_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> left_reg != 16'd0)
        else $error("body phase with no bytes left");

    // Collecting length digits needs a nonzero digit count.
    a_digits_expected: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DIGITS |-> expected_reg != 4'd0 && seen_reg < expected_reg)
        else $error("digit counters inconsistent");

    // A forwarded last byte ends the frame.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid && res.kind == KIND_DATA && res.last |=> phase_reg == PH_HUNT)
        else $error("last byte did not end the frame");

endmodule

>>> sv/ascii_length_frame_receiver_top.sv
// Top level of the ASCII length frame receiver: configuration registers,
// input and result registers around alfr_core. Depends on alfr_pkg and alfr_core.
//
// The receiver takes one beat per clock unless stalled: a byte (op 0) or one time
// tick (op 1). It hunts for the four-byte start_marker, then reads one ASCII
// digit n and n decimal length digits L, and forwards the next L+4 bytes
// (four ID bytes, then the payload, with last on the final one). A zero count,
// a leading zero or any non-digit in the length, a frame longer than
// max_frame, or timeout_ticks idle ticks in a partial frame produce one error
// beat instead, and the consumer should drop what it already received of that
// frame. Each beat passes through an input register and a single step of
// parsing logic into the result register, so a beat is accepted every cycle in
// which in_stall is low, and its result, if any, is presented on the outputs
// from the result register. The input register lets one new beat enter while a
// finished result still waits; only when that result is stalled and the input
// register is also full does in_stall rise. Configuration writes go to
// wr_index 0 (start marker), 1 (timeout ticks) and 2 (maximum frame) and
// should be made only while the block is idle; other indexes are ignored.
module ascii_length_frame_receiver_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [31:0] wr_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  frame_byte,
    output logic        is_id,
    output logic        last,
    output logic [1:0]  error_code
);
    import alfr_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t out_reg;
    result_t core_res;
    logic    advance;
    logic    step;
    logic    in_accept;

    // The result register can take a new value when it is empty or being read.
    assign advance   = !out_reg.valid || !out_stall;
    assign step      = item_valid_reg && advance;
    assign in_stall  = item_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker  <= START_MARKER_RESET;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RESET;
            cfg_reg.max_frame     <= MAX_FRAME_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_START_MARKER:  cfg_reg.start_marker  <= wr_data;
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= wr_data[15:0];
                REG_MAX_FRAME:     cfg_reg.max_frame     <= wr_data[15:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Input register: holds one beat until the parser steps on it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.op      <= op;
            item_reg.rx_byte <= rx_byte;
        end
    end

    alfr_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (advance)
        begin
            out_reg.valid <= step && core_res.valid;
            if (step && core_res.valid)
            begin
                out_reg.kind       <= core_res.kind;
                out_reg.frame_byte <= core_res.frame_byte;
                out_reg.is_id      <= core_res.is_id;
                out_reg.last       <= core_res.last;
                out_reg.error_code <= core_res.error_code;
            end
        end
    end

    assign out_valid  = out_reg.valid;
    assign kind       = out_reg.kind;
    assign frame_byte = out_reg.frame_byte;
    assign is_id      = out_reg.is_id;
    assign last       = out_reg.last;
    assign error_code = out_reg.error_code;

endmodule
